@@ src/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256 package
// types and constants shared by the byte stream hasher modules
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam logic [255:0] InitWords = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    init_word = InitWords[(3'd7 - idx) * 32 +: 32];
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ src/sha256_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256 round
// one compression round on registered working vars; the schedule word comes in on w_i
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic         clk_i,
  input  logic         load_i,
  input  logic         step_i,
  input  logic [255:0] chain_i,
  input  logic [31:0]  w_i,
  input  logic [5:0]   rnd_i,
  output logic [255:0] vars_o
);

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] t1, t2;
  logic [255:0] vars_q, vars_d;

  assign {a, b, c, d, e, f, g, h} = vars_q;

  always_comb begin
    t1 = h + (sha256_pkg::ror32(e, 6) ^ sha256_pkg::ror32(e, 11) ^ sha256_pkg::ror32(e, 25))
         + ((e & f) ^ (~e & g)) + sha256_pkg::round_k(rnd_i) + w_i;
    t2 = (sha256_pkg::ror32(a, 2) ^ sha256_pkg::ror32(a, 13) ^ sha256_pkg::ror32(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
    vars_d = vars_q;
    if (load_i) begin
      vars_d = chain_i;
    end else if (step_i) begin
      vars_d = {t1 + t2, a, b, c, d + t1, e, f, g};
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
  end

  assign vars_o = vars_q;

endmodule

@@ src/sha256_byte_stream_hasher_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256 byte stream hasher core
// sha-256 over a byte stream; message words kept in a 16-entry memory
// ----------------------------------------------------------------------------
//  channel | dir | payload                 | handshake
//  in      | in  | sha256_pkg::in_beat_t   | in_valid_i / in_ready_o
//  out     | out | sha256_pkg::out_beat_t  | out_valid_o / out_ready_i
//
//  each data beat is absorbed into the buffer; one that fills a block starts 64 rounds
//  (an RD and an RND state each) that run before the next beat is taken.
//  an end beat pads byte by byte and hashes one or two blocks,
//  then emits four digest beats.
//  reset loads the initial chaining words and clears length and fill level; the buffer needs none.
//  out_ready_i low holds the digest beats, and the input waits behind them.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha256_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha256_pkg::out_beat_t out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PAD, ST_LOAD, ST_RD, ST_RND, ST_FIN, ST_OUT
  } state_e;

  state_e       state_q;
  logic [255:0] chain_q;
  logic [60:0]  len_q;
  logic [5:0]   fill_q;
  logic [5:0]   rnd_q;
  logic         pad_q;    // padding in progress
  logic         fin_q;    // digest after current block
  logic [1:0]   widx_q;
  logic [31:0]  word_q;   // byte assembly
  logic         len_ok_q;   // length bytes go in the block being padded
  logic         pad_done_q; // set when the length bytes have gone in

  // 16-word schedule memory, one write and one registered read per cycle
  logic [31:0] wmem [16];
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata_q;
  // window reads: w[i-16], w[i-15], w[i-7], w[i-2] fetched one at a time from memory would be slow;
  // keep a 16-deep window of registers read at fixed taps instead of memory reads
  logic [31:0] win_q [16];

  always_ff @(posedge clk_i) begin
    if (we) wmem[waddr] <= wdata;
    rdata_q <= wmem[raddr];
  end

  logic       byte_push;
  logic [7:0] byte_val;
  logic [31:0] word_next;
  logic [31:0] sched_w, cur_w, s0, s1;
  logic [255:0] vars;
  logic        rload, rstep;

  always_comb begin
    word_next = {word_q[23:0], byte_val};
    s0 = sha256_pkg::ror32(win_q[1], 7) ^ sha256_pkg::ror32(win_q[1], 18) ^ (win_q[1] >> 3);
    s1 = sha256_pkg::ror32(win_q[14], 17) ^ sha256_pkg::ror32(win_q[14], 19)
         ^ (win_q[14] >> 10);
    sched_w = win_q[0] + s0 + win_q[9] + s1;
    cur_w = (rnd_q < 6'd16) ? rdata_q : sched_w;
  end

  sha256_round u_round (
    .clk_i  (clk_i),
    .load_i (rload),
    .step_i (rstep),
    .chain_i(chain_q),
    .w_i    (cur_w),
    .rnd_i  (rnd_q),
    .vars_o (vars)
  );

  logic [7:0] pad_byte;
  logic       len_here;
  always_comb begin
    // the block being padded carries the length if 0x80 landed before byte 56
    len_here = pad_q ? len_ok_q : (fill_q < sha256_pkg::LenStart);
    // padding bytes: 0x80 first, zeros, then length big-endian
    if (!pad_q) pad_byte = sha256_pkg::PadByte;
    else if (len_ok_q && fill_q >= sha256_pkg::LenStart)
      pad_byte = 8'({len_q, 3'b000} >> (6'd56 - {fill_q[2:0], 3'b000}));
    else pad_byte = 8'h00;
  end

  assign in_ready_o = (state_q == ST_IDLE);
  wire in_acc  = in_valid_i && in_ready_o;
  wire out_acc = out_valid_o && out_ready_i;

  always_comb begin
    byte_push = 1'b0;
    byte_val  = in_data_i.data_byte;
    if (state_q == ST_IDLE) byte_push = in_acc && in_data_i.byte_valid;
    if (state_q == ST_PAD) begin
      byte_push = 1'b1;
      byte_val = pad_byte;
    end
    we    = byte_push && (fill_q[1:0] == 2'b11);
    waddr = fill_q[5:2];
    wdata = word_next;
    // read in the RD cycle of round r lands for the RND cycle of round r
    raddr = rnd_q[3:0];
    rload = (state_q == ST_LOAD);
    rstep = (state_q == ST_RND);
  end

  always_ff @(posedge clk_i) begin
    if (byte_push) word_q <= word_next;
    if (state_q == ST_RND) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= cur_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      chain_q  <= sha256_pkg::InitWords;
      len_q    <= '0;
      fill_q   <= '0;
      rnd_q    <= '0;
      pad_q    <= 1'b0;
      fin_q    <= 1'b0;
      widx_q   <= '0;
      len_ok_q <= 1'b0;
    end else begin
      if (byte_push) fill_q <= fill_q + 6'd1;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data_i.byte_valid) len_q <= len_q + 61'd1;
            fin_q <= in_data_i.end_of_message;
            if (in_data_i.byte_valid && fill_q == 6'd63) state_q <= ST_LOAD;
            else if (in_data_i.end_of_message) state_q <= ST_PAD;
          end
        end
        ST_PAD: begin
          pad_q <= 1'b1;
          // a block closed without the length leaves it for the next one
          len_ok_q <= (fill_q == 6'd63) ? 1'b1 : len_here;
          if (fill_q == 6'd63) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          rnd_q   <= '0;
          state_q <= ST_RD;
        end
        ST_RD: state_q <= ST_RND;
        ST_RND: begin
          rnd_q <= rnd_q + 6'd1;
          state_q <= (rnd_q == 6'd63) ? ST_FIN : ST_RD;
        end
        ST_FIN: begin
          for (int i = 0; i < 8; i++)
            chain_q[i*32 +: 32] <= chain_q[i*32 +: 32] + vars[i*32 +: 32];
          if (!fin_q) state_q <= ST_IDLE;
          else if (pad_q && pad_done_q) state_q <= ST_OUT;
          else state_q <= ST_PAD;
          widx_q <= '0;
        end
        ST_OUT: begin
          if (out_acc) begin
            widx_q <= widx_q + 2'd1;
            if (widx_q == 2'd3) begin
              state_q  <= ST_IDLE;
              chain_q  <= sha256_pkg::InitWords;
              len_q    <= '0;
              fill_q   <= '0;
              pad_q    <= 1'b0;
              fin_q    <= 1'b0;
              len_ok_q <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // set when the block just closed holds the length (it is the last one)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pad_done_q <= 1'b0;
    else if (state_q == ST_OUT) pad_done_q <= 1'b0;
    else if (state_q == ST_PAD && fill_q == 6'd63) pad_done_q <= len_here;
  end

  assign out_valid_o = (state_q == ST_OUT);
  always_comb begin
    out_data_o.digest_word = chain_q[(2'd3 - widx_q) * 64 +: 64];
    out_data_o.word_index  = widx_q;
    out_data_o.last_word   = (widx_q == 2'd3);
  end

  // digest beats only leave when the final block has been folded in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fin_q) else $error("digest without end of message");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input taken during digest");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RND && rnd_q == 6'd63) |=> state_q == ST_FIN)
    else $error("round count slip");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256 byte stream hasher testbench
// drives byte and end-of-message beats with random gaps, predicts each
// digest with an in-bench sha-256 model and checks every digest beat in order
// ----------------------------------------------------------------------------
module testbench;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  sha256_pkg::in_beat_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  sha256_pkg::out_beat_t out_data;

  sha256_byte_stream_hasher_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // sha-256 constants
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // hash state of the predictor
  logic [31:0] hash_h [8];
  logic [60:0] msg_len;
  logic [7:0]  blk_buf [64];
  logic [5:0]  blk_fill;

  sha256_pkg::in_beat_t  pending_beats [$];
  sha256_pkg::out_beat_t digest_expected [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  recv_hold;
  int  hold_cycles;
  int  mismatches = 0;
  int  accepted_beats = 0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    v = hash_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endtask

  task automatic absorb_byte(logic [7:0] b);
    blk_buf[blk_fill] = b;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress_block();
  endtask

  task automatic hash_restart();
    hash_h   = StartHash;
    msg_len  = '0;
    blk_fill = '0;
  endtask

  // one accepted input beat: absorb, and on end of message pad and queue digest
  task automatic predict_digest(sha256_pkg::in_beat_t beat);
    logic [63:0]           bit_len;
    sha256_pkg::out_beat_t o;
    if (beat.byte_valid) begin
      msg_len = msg_len + 61'd1;
      absorb_byte(beat.data_byte);
    end
    if (beat.end_of_message) begin
      bit_len = {msg_len, 3'b000};
      absorb_byte(sha256_pkg::PadByte);
      while (blk_fill != sha256_pkg::LenStart) absorb_byte(8'h00);
      for (int k = 0; k < 8; k++) absorb_byte(bit_len[63 - 8*k -: 8]);
      for (int k = 0; k < 4; k++) begin
        o.digest_word = {hash_h[2*k], hash_h[2*k+1]};
        o.word_index  = k[1:0];
        o.last_word   = (k == 3);
        digest_expected = {digest_expected, o};
      end
      hash_restart();
    end
  endtask

  function automatic sha256_pkg::in_beat_t make_beat(logic [7:0] d, bit v, bit e);
    sha256_pkg::in_beat_t b;
    b.data_byte = d;
    b.byte_valid = v;
    b.end_of_message = e;
    return b;
  endfunction

  task automatic enqueue_beat(sha256_pkg::in_beat_t b);
    pending_beats = {pending_beats, b};
  endtask

  task automatic queue_message(int len, bit end_carries_byte);
    for (int i = 0; i < len; i++) begin
      // occasional empty beats inside a message
      if ($urandom_range(0, 9) == 0)
        enqueue_beat(make_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      enqueue_beat(make_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0));
    end
    enqueue_beat(make_beat(8'($urandom_range(0, 255)), end_carries_byte, 1'b1));
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: beat held until accepted, payload stays put
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      hash_restart();
    end else begin
      if (in_valid && in_ready) begin
        predict_digest(in_data);
        accepted_beats <= accepted_beats + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver backpressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_expected.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected digest beat %h", out_data);
        end else begin
          sha256_pkg::out_beat_t e;
          e = digest_expected.pop_front();
          if (out_data.digest_word !== e.digest_word || out_data.word_index !== e.word_index
              || out_data.last_word !== e.last_word) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("digest mismatch: exp %h idx %0d last %0d, got %h idx %0d last %0d",
                       e.digest_word, e.word_index, e.last_word, out_data.digest_word,
                       out_data.word_index, out_data.last_word);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready   <= 1'b0;
      end else if (recv_hold) begin
        hold_cycles <= 600;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int n;
    send_idle_pct  = 32;
    recv_idle_pct  = 79;
    recv_hold      = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, byte-free end, field extremes, padding edges
    enqueue_beat(make_beat(8'h00, 1'b0, 1'b1));
    enqueue_beat(make_beat(8'hff, 1'b0, 1'b0));
    enqueue_beat(make_beat(8'h00, 1'b1, 1'b0));
    enqueue_beat(make_beat(8'hff, 1'b1, 1'b1));
    enqueue_beat(make_beat(8'h61, 1'b1, 1'b0));
    enqueue_beat(make_beat(8'h62, 1'b1, 1'b0));
    enqueue_beat(make_beat(8'h63, 1'b0, 1'b1));
    enqueue_beat(make_beat(8'haa, 1'b1, 1'b1));
    queue_message(55, 1'b0);
    queue_message(55, 1'b1);
    queue_message(63, 1'b1);

    // random messages, mostly short, a few across block edges
    n = 0;
    while (n < 130) begin
      int len;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      queue_message(len, 1'($urandom_range(0, 1)));
      n = n + len + 1;
    end

    // long stall on the output side while beats keep coming
    wait (accepted_beats > 60);
    @(posedge clk);
    recv_hold <= 1'b1;
    @(posedge clk);
    recv_hold <= 1'b0;

    wait (pending_beats.size() < 230);
    send_idle_pct = 79;
    recv_idle_pct = 32;
    wait (pending_beats.size() < 115);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    wait (pending_beats.size() == 0 && !in_valid);
    wait (digest_expected.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sha256_byte_stream_hasher_core.f @@
src/sha256_pkg.sv
src/sha256_round.sv
src/sha256_byte_stream_hasher_core.sv
dv/testbench.sv
